[design/pss_pkg.sv]
// shared constants, tables and helpers for the scale-mapped sine synthesizer
`default_nettype none

package pss_pkg;

	// parameter defaults for the top level
	localparam int unsigned NUM_KEYS_DEF    = 40;
	localparam int unsigned SAMPLE_RATE_DEF = 48000;
	localparam int unsigned PHASE_BITS_DEF  = 24;
	localparam int unsigned SINE_DEPTH_DEF  = 1024;

	// fixed field widths
	localparam int unsigned KEY_MASK_W = 40;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned COUNT_W    = 16;

	// shared multiplier
	localparam int unsigned MUL_W  = 32;
	localparam int unsigned PROD_W = 2 * MUL_W;

	// turn position: two quadrant bits over a 16-bit quadrant fraction
	localparam int unsigned TURN_BITS   = 18;
	localparam int unsigned RECIP_SHIFT = 17;

	// pitch constants
	localparam int unsigned SEMIS     = 12;
	localparam int unsigned FREQ_W    = 26;
	localparam int unsigned FREQ_FRAC = 16;
	localparam int unsigned OCT_TOP   = 4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TONIC = 2'd0,
		REG_SCALE = 2'd1,
		REG_GAIN  = 2'd2
	} cfg_reg_t;

	// 440 * 2^(s/12) Hz in Q10.16, one entry per semitone step
	localparam logic [FREQ_W-1:0] BASE_FREQ_Q16 [SEMIS] = '{
		26'd28835840, 26'd30550508, 26'd32367136, 26'd34291786,
		26'd36330882, 26'd38491228, 26'd40780036, 26'd43204943,
		26'd45774043, 26'd48495909, 26'd51379626, 26'd54434817
	};

	// odd Taylor coefficients of sin(pi/2 x), Q30
	localparam logic [MUL_W-1:0] SIN_C1 = 32'd1686629713;
	localparam logic [MUL_W-1:0] SIN_C3 = 32'd693598669;
	localparam logic [MUL_W-1:0] SIN_C5 = 32'd85569306;
	localparam logic [MUL_W-1:0] SIN_C7 = 32'd5026995;

	localparam logic [14:0] Q15_MAX = 15'h7fff;

	// semitone of a scale degree 0..6, major or natural minor
	function automatic logic [3:0] scale_step(input logic minor, input logic [2:0] deg);
		logic [3:0] st;
		case (deg)
			3'd0:    st = 4'd0;
			3'd1:    st = 4'd2;
			3'd2:    st = minor ? 4'd3 : 4'd4;
			3'd3:    st = 4'd5;
			3'd4:    st = 4'd7;
			3'd5:    st = minor ? 4'd8 : 4'd9;
			3'd6:    st = minor ? 4'd10 : 4'd11;
			default: st = 4'd0;
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

[design/pss_mul.sv]
// shared unsigned multiplier with registered product
`default_nettype none

module pss_mul
	import pss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [MUL_W-1:0]  a,
	input  wire logic [MUL_W-1:0]  b,
	output logic      [PROD_W-1:0] prod
);

	// one product per cycle, operands come from registers
	always_ff @(posedge clk) begin
		prod <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

[design/polyphonic_scale_sine_synth_unit.sv]
// top level: key scan sequencer around one shared multiplier
// each held key takes ten products of the shared 32x32 multiplier
// one item at a time: the next beat is taken once the result sits in the output register
// reset: tonic 3, natural minor, gain 4269, sample counter 0, output empty
`default_nettype none

module polyphonic_scale_sine_synth_unit
	import pss_pkg::*;
#(
	parameter int unsigned NUM_KEYS         = NUM_KEYS_DEF,
	parameter int unsigned SAMPLE_RATE      = SAMPLE_RATE_DEF,
	parameter int unsigned PHASE_BITS       = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [KEY_MASK_W-1:0] s_tdata,   // [39:0] key_mask
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [15:0]           cfg_data
);

	localparam int unsigned KEY_SCAN = (NUM_KEYS < KEY_MASK_W) ? NUM_KEYS : KEY_MASK_W;
	localparam int unsigned ACC_W    = $clog2(KEY_SCAN) + 16;
	localparam int unsigned IDX_W    = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned REM_W    = IDX_W + TURN_BITS + 1;
	localparam int unsigned E_TOP    = PHASE_BITS - FREQ_FRAC + OCT_TOP;
	localparam int unsigned BINC_W   = FREQ_W + E_TOP;
	localparam logic [63:0] RECIP    =
		(64'd1 << (TURN_BITS + RECIP_SHIFT)) / 64'(SINE_TABLE_DEPTH);
	localparam int unsigned COLS     = 10;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_POST,
		S_GAIN,
		S_FINAL
	} state_t;

	// names the product being formed in the multiplier
	typedef enum logic [3:0] {
		ST_PHASE,
		ST_INDEX,
		ST_RECIP,
		ST_CHECK,
		ST_SQUARE,
		ST_POLY1,
		ST_POLY2,
		ST_POLY3,
		ST_SIN,
		ST_SCALE,
		ST_GAIN
	} step_t;

	// configuration registers
	logic [3:0]  tonic_q;
	logic        scale_q;
	logic [15:0] gain_q;

	// sequencer state
	state_t                   state_q;
	step_t                    step_q;
	logic [KEY_SCAN-1:0]      mask_q;
	logic [3:0]               col_q;
	logic [1:0]               row_q;
	logic                     any_q;
	logic [COUNT_W-1:0]       count_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [IDX_W-1:0]         idx_q;
	logic [TURN_BITS-1:0]     qe_q;
	logic [1:0]               quad_q;
	logic [16:0]              x_q;
	logic [30:0]              x2_q;
	logic [MUL_W-1:0]         a_q;
	logic [MUL_W-1:0]         b_q;
	logic                     m_tvalid_q;
	logic [SAMPLE_W-1:0]      m_tdata_q;

	logic [PROD_W-1:0] prod;

	pss_mul u_mul (
		.clk  (clk),
		.a    (a_q),
		.b    (b_q),
		.prod (prod)
	);

	// config writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tonic_q <= 4'd3;
			scale_q <= 1'b1;
			gain_q  <= 16'd4269;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TONIC: tonic_q <= cfg_data[3:0];
				REG_SCALE: scale_q <= cfg_data[0];
				REG_GAIN:  gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-semitone phase increments at the top octave, worked out at elaboration
	logic [BINC_W-1:0] base_inc [SEMIS];

	for (genvar gi = 0; gi < SEMIS; gi++) begin : g_inc
		localparam logic [63:0] INC =
			(64'(BASE_FREQ_Q16[gi]) << E_TOP) / 64'(SAMPLE_RATE);
		assign base_inc[gi] = INC[BINC_W-1:0];
	end

	// key position to phase increment
	logic                  wrap;
	logic [2:0]            deg;
	logic [4:0]            semi;
	logic [1:0]            a_oct;
	logic [3:0]            st;
	logic [2:0]            shift_amt;
	logic [BINC_W-1:0]     inc_full;
	logic [PHASE_BITS-1:0] inc_v;

	always_comb begin
		wrap = (col_q >= 4'd7);
		deg  = wrap ? 3'(col_q - 4'd7) : col_q[2:0];
		semi = 5'(scale_step(scale_q, deg)) + 5'(tonic_q);
		if (semi >= 5'(2 * SEMIS)) begin
			a_oct = 2'd2;
			st    = 4'(semi - 5'(2 * SEMIS));
		end else if (semi >= 5'(SEMIS)) begin
			a_oct = 2'd1;
			st    = 4'(semi - 5'(SEMIS));
		end else begin
			a_oct = 2'd0;
			st    = semi[3:0];
		end
		// distance below the top octave
		shift_amt = 3'(4'(OCT_TOP - 1) + 4'(row_q) - 4'(wrap) - 4'(a_oct));
		inc_full  = base_inc[st] >> shift_amt;
		inc_v     = inc_full[PHASE_BITS-1:0];
	end

	// post-processing of the product in flight
	logic [PHASE_BITS-1:0]   phase_v;
	logic [IDX_W-1:0]        idx_v;
	logic [TURN_BITS-1:0]    qe_v;
	logic [REM_W-1:0]        rem_v;
	logic [TURN_BITS-1:0]    turn_v;
	logic [16:0]             x_v;
	logic [MUL_W-1:0]        coef_v;
	logic [MUL_W-1:0]        t_v;
	logic [MUL_W-1:0]        r_v;
	logic [46:0]             s_sum;
	logic [16:0]             s_raw;
	logic [14:0]             s_mag;
	logic signed [ACC_W-1:0] s_val;
	logic [ACC_W-1:0]        acc_mag;
	logic [PROD_W-1:0]       g_sum;
	logic [48:0]             g_r;
	logic [SAMPLE_W-1:0]     sample_v;
	logic [KEY_SCAN-1:0]     mask_next;

	always_comb begin
		phase_v = prod[PHASE_BITS-1:0];
		idx_v   = prod[PHASE_BITS +: IDX_W];
		qe_v    = prod[RECIP_SHIFT +: TURN_BITS];
		// reciprocal estimate is at most one short
		rem_v   = REM_W'({idx_q, TURN_BITS'(0)}) - prod[REM_W-1:0];
		turn_v  = (rem_v >= REM_W'(SINE_TABLE_DEPTH)) ? qe_q + 1'b1 : qe_q;
		x_v     = turn_v[16] ? 17'h10000 - {1'b0, turn_v[15:0]} : {1'b0, turn_v[15:0]};
		// horner steps of the polynomial
		case (step_q)
			ST_POLY1: coef_v = SIN_C5;
			ST_POLY2: coef_v = SIN_C3;
			default:  coef_v = SIN_C1;
		endcase
		t_v     = coef_v - prod[61:30];
		r_v     = prod[47:16];
		// round to Q15, limit, sign by quadrant
		s_sum   = prod[46:0] + 47'(1 << 29);
		s_raw   = s_sum[46:30];
		s_mag   = (s_raw > 17'(Q15_MAX)) ? Q15_MAX : s_raw[14:0];
		s_val   = quad_q[1] ? -$signed(ACC_W'(s_mag)) : $signed(ACC_W'(s_mag));
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		// gain product rounded half away from zero and saturated
		g_sum   = prod + 64'd16384;
		g_r     = g_sum[63:15];
		if (!any_q) begin
			sample_v = '0;
		end else if (acc_q[ACC_W-1]) begin
			sample_v = (g_r > 49'd32768) ? 16'h8000 : 16'(-g_r);
		end else begin
			sample_v = (g_r > 49'd32767) ? 16'h7fff : g_r[15:0];
		end
		mask_next = mask_q >> 1;
	end

	logic final_fire;
	logic [KEY_SCAN-1:0] in_mask;

	assign in_mask    = s_tdata[KEY_SCAN-1:0];
	assign final_fire = (state_q == S_FINAL) && (!m_tvalid_q || m_tready);
	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	// sequencer, operand registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= ST_PHASE;
			mask_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			any_q      <= 1'b0;
			count_q    <= '0;
			acc_q      <= '0;
			idx_q      <= '0;
			qe_q       <= '0;
			quad_q     <= '0;
			x_q        <= '0;
			x2_q       <= '0;
			a_q        <= '0;
			b_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// output beat handshake
			if (final_fire) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= sample_v;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mask_q  <= in_mask;
						any_q   <= |in_mask;
						col_q   <= '0;
						row_q   <= '0;
						acc_q   <= '0;
						state_q <= (|in_mask) ? S_SCAN : S_FINAL;
					end
				end
				S_SCAN: begin
					if (mask_q[0]) begin
						a_q     <= MUL_W'(count_q);
						b_q     <= MUL_W'(inc_v);
						step_q  <= ST_PHASE;
						state_q <= S_MUL;
					end else begin
						mask_q <= mask_next;
						if (col_q == 4'(COLS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_MUL: begin
					state_q <= S_POST;
				end
				S_POST: begin
					state_q <= S_MUL;
					unique case (step_q)
						ST_PHASE: begin
							a_q    <= MUL_W'(phase_v);
							b_q    <= MUL_W'(SINE_TABLE_DEPTH);
							step_q <= ST_INDEX;
						end
						ST_INDEX: begin
							idx_q  <= idx_v;
							a_q    <= MUL_W'(idx_v);
							b_q    <= MUL_W'(RECIP);
							step_q <= ST_RECIP;
						end
						ST_RECIP: begin
							qe_q   <= qe_v;
							a_q    <= MUL_W'(qe_v);
							b_q    <= MUL_W'(SINE_TABLE_DEPTH);
							step_q <= ST_CHECK;
						end
						ST_CHECK: begin
							quad_q <= turn_v[17:16];
							x_q    <= x_v;
							a_q    <= MUL_W'(x_v);
							b_q    <= MUL_W'(x_v);
							step_q <= ST_SQUARE;
						end
						ST_SQUARE: begin
							x2_q   <= prod[32:2];
							a_q    <= MUL_W'(prod[32:2]);
							b_q    <= SIN_C7;
							step_q <= ST_POLY1;
						end
						ST_POLY1: begin
							a_q    <= MUL_W'(x2_q);
							b_q    <= t_v;
							step_q <= ST_POLY2;
						end
						ST_POLY2: begin
							a_q    <= MUL_W'(x2_q);
							b_q    <= t_v;
							step_q <= ST_POLY3;
						end
						ST_POLY3: begin
							a_q    <= MUL_W'(x_q);
							b_q    <= t_v;
							step_q <= ST_SIN;
						end
						ST_SIN: begin
							a_q    <= r_v;
							b_q    <= MUL_W'(Q15_MAX);
							step_q <= ST_SCALE;
						end
						ST_SCALE: begin
							acc_q  <= acc_q + s_val;
							mask_q <= mask_next;
							if (col_q == 4'(COLS - 1)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							state_q <= (mask_next == '0) ? S_GAIN : S_SCAN;
						end
						ST_GAIN: begin
							state_q <= S_FINAL;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_GAIN: begin
					a_q     <= MUL_W'(acc_mag);
					b_q     <= MUL_W'(gain_q);
					step_q  <= ST_GAIN;
					state_q <= S_MUL;
				end
				S_FINAL: begin
					if (final_fire) begin
						if (any_q) begin
							count_q <= (count_q == COUNT_W'(SAMPLE_RATE - 1)) ?
								'0 : count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sample counter never reaches the rate
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q < COUNT_W'(SAMPLE_RATE))
		else $error("sample counter out of range");

	// time moves only with a result that had keys held
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(final_fire && any_q))
		else $error("sample counter moved without a result");

	// scanning only while held keys remain
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (mask_q != '0))
		else $error("key scan with empty mask");

	// reciprocal quotient estimate within one of the true quotient
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && step_q == ST_CHECK) |->
			(rem_v < REM_W'(2 * SINE_TABLE_DEPTH)))
		else $error("turn position estimate off by more than one");

	// an accepted input beat keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("idle right after an input beat");

endmodule

`default_nettype wire
